[rtl/cqi_pkg.sv]
// ----------------------------------------------------------------------------
// cqi_pkg
// Shared widths, character codes, microcode format and the program ROM of
// the cursor query interceptor.
// ----------------------------------------------------------------------------
package cqi_pkg;

   localparam int DATA_WIDTH          = 8;
   localparam int COORD_PORT_WIDTH    = 16;
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int STEP_WIDTH          = 4;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SIX      = 8'h36;
   localparam logic [7:0] CH_LOWER_N  = 8'h6E;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_UPPER_R  = 8'h52;
   localparam logic [3:0] CH_DIGIT_HI = 4'h3;

   localparam logic ROUTE_TERM  = 1'b0;
   localparam logic ROUTE_REPLY = 1'b1;

   localparam logic [STEP_WIDTH-1:0] STEP_ACCEPT = 4'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_FLUSH  = 4'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_PASS   = 4'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_REPLY  = 4'd3;

   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_FLUSH,
      OP_PASS,
      OP_CONST,
      OP_LOAD_ROW,
      OP_LOAD_COL,
      OP_DABBLE,
      OP_DIGITS
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [7:0]            byte_val;
      logic                  last;
      logic [STEP_WIDTH-1:0] next;
   } ucode_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic digit_shift;
   } bcd_ctrl_type;

   // Bytes of the cursor position query, in order.
   function automatic logic [7:0] query_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = CH_ESC;
         2'd1:    b = CH_LBRACKET;
         2'd2:    b = CH_SIX;
         default: b = CH_LOWER_N;
      endcase
      return b;
   endfunction

   // The control program. The accept step falls through to the flush path
   // and branches to the reply path on a complete query.
   function automatic ucode_type ucode_rom(input logic [STEP_WIDTH-1:0] step);
      ucode_type w;
      case (step)
         4'd0:    w = '{OP_ACCEPT,   8'h00,       1'b0, STEP_FLUSH};
         4'd1:    w = '{OP_FLUSH,    8'h00,       1'b0, STEP_PASS};
         4'd2:    w = '{OP_PASS,     8'h00,       1'b1, STEP_ACCEPT};
         4'd3:    w = '{OP_CONST,    CH_ESC,      1'b0, 4'd4};
         4'd4:    w = '{OP_CONST,    CH_LBRACKET, 1'b0, 4'd5};
         4'd5:    w = '{OP_LOAD_ROW, 8'h00,       1'b0, 4'd6};
         4'd6:    w = '{OP_DABBLE,   8'h00,       1'b0, 4'd7};
         4'd7:    w = '{OP_DIGITS,   8'h00,       1'b0, 4'd8};
         4'd8:    w = '{OP_CONST,    CH_SEMI,     1'b0, 4'd9};
         4'd9:    w = '{OP_LOAD_COL, 8'h00,       1'b0, 4'd10};
         4'd10:   w = '{OP_DABBLE,   8'h00,       1'b0, 4'd11};
         4'd11:   w = '{OP_DIGITS,   8'h00,       1'b0, 4'd12};
         4'd12:   w = '{OP_CONST,    CH_UPPER_R,  1'b1, STEP_ACCEPT};
         default: w = '{OP_ACCEPT,   8'h00,       1'b0, STEP_FLUSH};
      endcase
      return w;
   endfunction

endpackage

[rtl/cqi_req_if.sv]
// ----------------------------------------------------------------------------
// cqi_req_if
// Input channel: bytes written by the program plus the current cursor.
// ----------------------------------------------------------------------------
interface cqi_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cqi_pkg::DATA_WIDTH-1:0]       data_byte;
   logic [cqi_pkg::COORD_PORT_WIDTH-1:0] cursor_row;
   logic [cqi_pkg::COORD_PORT_WIDTH-1:0] cursor_col;

   modport source (output valid, data_byte, cursor_row, cursor_col, input ready);
   modport sink   (input valid, data_byte, cursor_row, cursor_col, output ready);
endinterface

[rtl/cqi_rsp_if.sv]
// ----------------------------------------------------------------------------
// cqi_rsp_if
// Result channel: one emitted byte with its route and end marker.
// ----------------------------------------------------------------------------
interface cqi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cqi_pkg::DATA_WIDTH-1:0] out_byte;
   logic                           route;
   logic                           last;

   modport source (output valid, out_byte, route, last, input ready);
   modport sink   (input valid, out_byte, route, last, output ready);
endinterface

[rtl/cqi_bcd.sv]
// ----------------------------------------------------------------------------
// cqi_bcd
// Binary to decimal converter: shift-and-add-3, one bit per cycle, then
// digits are shifted out most significant first.
// ----------------------------------------------------------------------------
module cqi_bcd #(
   parameter int VAL_WIDTH  = 17,
   parameter int NUM_DIGITS = 6
) (
   input  logic                   clock,
   input  cqi_pkg::bcd_ctrl_type  ctrl,
   input  logic [VAL_WIDTH-1:0]   load_value,
   output logic [3:0]             top_digit
);

   localparam int BCD_WIDTH = NUM_DIGITS * 4;

   logic [VAL_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0] bcd_adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = load_value;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = {bin_ff[VAL_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VAL_WIDTH-1]};
      end else if (ctrl.digit_shift) begin
         bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];

endmodule

[rtl/cursor_query_interceptor.sv]
// ----------------------------------------------------------------------------
// cursor_query_interceptor
// Filters a program's byte stream toward a terminal, swallowing cursor
// position queries and answering them with a position report.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Carries
//  req_ch   in   valid / ready      data_byte, cursor_row, cursor_col
//  rsp_ch   out  valid / ready      out_byte, route, last
//  csr_*    in   csr_wr_en          emulate_enable
//
// A byte that extends a partial query yields nothing. A pass-through or
// mismatch releases any held prefix bytes, then the byte itself. A reply
// is paced by the converter's one bit per cycle shift and one digit per
// cycle readout; the readout waits while the result channel is busy.
// Reset is synchronous and enables emulation with no prefix held. A
// stalled result channel holds the sequencer at its emitting step.
// ----------------------------------------------------------------------------
module cursor_query_interceptor #(
   parameter int COORD_WIDTH = cqi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   cqi_req_if.sink         req_ch,
   cqi_rsp_if.source       rsp_ch,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   localparam int PORT_W     = cqi_pkg::COORD_PORT_WIDTH;
   localparam int CAP_WIDTH  = (COORD_WIDTH < PORT_W) ? COORD_WIDTH : PORT_W;
   localparam int VAL_WIDTH  = COORD_WIDTH + 1;
   localparam int NUM_DIGITS = (VAL_WIDTH * 30103) / 100000 + 1;
   localparam int CNT_WIDTH  = $clog2(VAL_WIDTH + 1);

   logic [cqi_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic                           enable_ff;
   logic [1:0]                     match_ff, match_in;
   logic [1:0]                     flush_len_ff, flush_len_in;
   logic [7:0]                     byte_ff, byte_in;
   logic [COORD_WIDTH-1:0]         row_ff, row_in;
   logic [COORD_WIDTH-1:0]         col_ff, col_in;
   logic [CNT_WIDTH-1:0]           cnt_ff, cnt_in;
   logic                           started_ff, started_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_byte_ff, rsp_byte_in;
   logic                           rsp_route_ff, rsp_route_in;
   logic                           rsp_last_ff, rsp_last_in;

   cqi_pkg::ucode_type    uc;
   cqi_pkg::bcd_ctrl_type bcd_ctrl;
   logic [VAL_WIDTH-1:0]  load_value;
   logic [3:0]            top_digit;
   logic                  accept;
   logic                  out_free;
   logic                  emit;
   logic [7:0]            emit_byte;
   logic                  emit_route;
   logic                  emit_last;

   cqi_bcd #(
      .VAL_WIDTH  (VAL_WIDTH),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_bcd (
      .clock      (clock),
      .ctrl       (bcd_ctrl),
      .load_value (load_value),
      .top_digit  (top_digit)
   );

   assign uc       = cqi_pkg::ucode_rom(step_ff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (uc.op == cqi_pkg::OP_ACCEPT);
   assign accept   = req_ch.valid && req_ch.ready;

   // The reported numbers are one-based and keep the carry out of the top bit.
   assign load_value = (uc.op == cqi_pkg::OP_LOAD_COL)
                       ? ({1'b0, col_ff} + VAL_WIDTH'(1))
                       : ({1'b0, row_ff} + VAL_WIDTH'(1));

   always_comb begin
      step_in      = step_ff;
      match_in     = match_ff;
      flush_len_in = flush_len_ff;
      byte_in      = byte_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      started_in   = started_ff;
      bcd_ctrl     = '0;
      emit         = 1'b0;
      emit_byte    = 8'h00;
      emit_route   = cqi_pkg::ROUTE_TERM;
      emit_last    = 1'b0;

      case (uc.op)
         cqi_pkg::OP_ACCEPT: begin
            if (accept) begin
               byte_in = req_ch.data_byte;
               row_in  = COORD_WIDTH'(req_ch.cursor_row[CAP_WIDTH-1:0]);
               col_in  = COORD_WIDTH'(req_ch.cursor_col[CAP_WIDTH-1:0]);
               cnt_in  = '0;
               if (!enable_ff || req_ch.data_byte != cqi_pkg::query_byte(match_ff)) begin
                  flush_len_in = match_ff;
                  match_in     = 2'd0;
                  step_in      = uc.next;
               end else if (match_ff == 2'd3) begin
                  match_in = 2'd0;
                  step_in  = cqi_pkg::STEP_REPLY;
               end else begin
                  match_in = match_ff + 2'd1;
               end
            end
         end
         cqi_pkg::OP_FLUSH: begin
            if (cnt_ff == CNT_WIDTH'(flush_len_ff)) begin
               cnt_in  = '0;
               step_in = uc.next;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_byte = cqi_pkg::query_byte(cnt_ff[1:0]);
               cnt_in    = cnt_ff + CNT_WIDTH'(1);
            end
         end
         cqi_pkg::OP_PASS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = byte_ff;
               emit_last = uc.last;
               step_in   = uc.next;
            end
         end
         cqi_pkg::OP_CONST: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_byte  = uc.byte_val;
               emit_route = cqi_pkg::ROUTE_REPLY;
               emit_last  = uc.last;
               step_in    = uc.next;
            end
         end
         cqi_pkg::OP_LOAD_ROW, cqi_pkg::OP_LOAD_COL: begin
            bcd_ctrl.load = 1'b1;
            cnt_in        = CNT_WIDTH'(VAL_WIDTH);
            step_in       = uc.next;
         end
         cqi_pkg::OP_DABBLE: begin
            if (cnt_ff == '0) begin
               cnt_in     = CNT_WIDTH'(NUM_DIGITS);
               started_in = 1'b0;
               step_in    = uc.next;
            end else begin
               bcd_ctrl.dabble = 1'b1;
               cnt_in          = cnt_ff - CNT_WIDTH'(1);
            end
         end
         cqi_pkg::OP_DIGITS: begin
            if (cnt_ff == '0) begin
               step_in = uc.next;
            end else if (top_digit == 4'h0 && !started_ff && cnt_ff != CNT_WIDTH'(1)) begin
               // Leading zeros are dropped, but the units digit always goes out.
               bcd_ctrl.digit_shift = 1'b1;
               cnt_in               = cnt_ff - CNT_WIDTH'(1);
            end else if (out_free) begin
               emit                 = 1'b1;
               emit_byte            = {cqi_pkg::CH_DIGIT_HI, top_digit};
               emit_route           = cqi_pkg::ROUTE_REPLY;
               bcd_ctrl.digit_shift = 1'b1;
               started_in           = 1'b1;
               cnt_in               = cnt_ff - CNT_WIDTH'(1);
            end
         end
         default: begin
            step_in = cqi_pkg::STEP_ACCEPT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_route_in = rsp_route_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_route_in = emit_route;
         rsp_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= cqi_pkg::STEP_ACCEPT;
         enable_ff    <= 1'b1;
         match_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      flush_len_ff <= flush_len_in;
      byte_ff      <= byte_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      cnt_ff       <= cnt_in;
      started_ff   <= started_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_route_ff <= rsp_route_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.route    = rsp_route_ff;
   assign rsp_ch.last     = rsp_last_ff;

   // An accepted byte either starts a sequence or advances the match.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff != cqi_pkg::STEP_ACCEPT) || (match_ff != 2'd0))
      else $error("accepted transaction was dropped by the sequencer");

   // The match count moves only when a transaction is accepted.
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> match_ff == $past(match_ff))
      else $error("match count changed without a transaction");

   // A reply always ends with the final letter of the report.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_route_ff == cqi_pkg::ROUTE_REPLY && rsp_last_ff
      |-> rsp_byte_ff == cqi_pkg::CH_UPPER_R)
      else $error("reply ended with the wrong byte");

   // Released prefix bytes go to the terminal.
   assert property (@(posedge clock) disable iff (reset)
      emit && step_ff == cqi_pkg::STEP_FLUSH |=> rsp_route_ff == cqi_pkg::ROUTE_TERM)
      else $error("flushed prefix took the reply route");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor query interceptor. A scoreboard class
// tracks the query match state and the emulation enable, predicts the byte
// stream on both routes for every accepted write, and compares each emitted
// byte field by field. Directed cases cover coordinate extremes, decimal
// carries and every broken prefix; random traffic is half whole queries,
// half noise, run under several flow control mixes and enable values.
// ----------------------------------------------------------------------------
module tb;

   localparam int COORD_W        = cqi_pkg::COORD_WIDTH_DEFAULT;
   localparam int SETTLE_CYCLES  = 80;
   localparam int LONG_HOLD      = 400;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [7:0] out_byte;
      logic       route;
      logic       last;
   } emitted_byte_type;

   class cursor_report_scoreboard_type;
      bit               emulate_on;
      bit [2:0]         match_len;
      logic [7:0]       query_chars[4];
      emitted_byte_type owed_q[$];
      int               mismatch_count;

      function new();
         query_chars[0] = cqi_pkg::CH_ESC;
         query_chars[1] = cqi_pkg::CH_LBRACKET;
         query_chars[2] = cqi_pkg::CH_SIX;
         query_chars[3] = cqi_pkg::CH_LOWER_N;
         mismatch_count = 0;
         reset_state();
      endfunction

      function void reset_state();
         emulate_on = 1'b1;
         match_len  = '0;
         owed_q.delete();
      endfunction

      function void write_emulate(bit value);
         emulate_on = value;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void owe(logic [7:0] b, logic route);
         emitted_byte_type e;
         e.out_byte = b;
         e.route    = route;
         e.last     = 1'b0;
         owed_q.push_back(e);
      endfunction

      function void owe_decimal(longint unsigned value);
         logic [3:0] digits[24];
         int         n;
         longint unsigned v;
         n = 0;
         v = value;
         do begin
            digits[n] = 4'(v % 10);
            n++;
            v = v / 10;
         end while (v != 0);
         while (n > 0) begin
            n--;
            owe({cqi_pkg::CH_DIGIT_HI, digits[n]}, cqi_pkg::ROUTE_REPLY);
         end
      endfunction

      function void release_prefix();
         for (int j = 0; j < match_len; j++)
            owe(query_chars[j], cqi_pkg::ROUTE_TERM);
         match_len = '0;
      endfunction

      function void note_written_byte(logic [7:0] b, logic [15:0] row, logic [15:0] col);
         longint unsigned mask;
         longint unsigned r;
         longint unsigned c;
         mask = (64'd1 << COORD_W) - 1;
         r    = longint'(row) & mask;
         c    = longint'(col) & mask;
         if (!emulate_on) begin
            release_prefix();
            owe(b, cqi_pkg::ROUTE_TERM);
         end else if (b == query_chars[match_len]) begin
            match_len++;
            if (match_len < 4)
               return;
            match_len = '0;
            owe(cqi_pkg::CH_ESC, cqi_pkg::ROUTE_REPLY);
            owe(cqi_pkg::CH_LBRACKET, cqi_pkg::ROUTE_REPLY);
            owe_decimal(r + 1);
            owe(cqi_pkg::CH_SEMI, cqi_pkg::ROUTE_REPLY);
            owe_decimal(c + 1);
            owe(cqi_pkg::CH_UPPER_R, cqi_pkg::ROUTE_REPLY);
         end else begin
            release_prefix();
            owe(b, cqi_pkg::ROUTE_TERM);
         end
         owed_q[owed_q.size() - 1].last = 1'b1;
      endfunction

      function void check_emitted_byte(logic [7:0] b, logic route, logic last);
         emitted_byte_type e;
         if (owed_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected transaction: byte %02h route %0d last %0d",
                        b, route, last);
            return;
         end
         e = owed_q.pop_front();
         if (e.out_byte !== b || e.route !== route || e.last !== last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"mismatch: expected byte %02h route %0d last %0d,",
                         " got byte %02h route %0d last %0d"},
                        e.out_byte, e.route, e.last, b, route, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   cqi_req_if req_ch();
   cqi_rsp_if rsp_ch();

   cursor_query_interceptor #(.COORD_WIDTH(COORD_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cursor_report_scoreboard_type sb = new();

   int send_idle_pct;
   int recv_idle_pct;
   int hold_asked;
   int hold_served;
   int hold_left;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver flow control; a requested long hold is timed here.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         hold_served  <= hold_asked;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sb.reset_state();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_emitted_byte(rsp_ch.out_byte, rsp_ch.route, rsp_ch.last);
         if (req_ch.valid && req_ch.ready)
            sb.note_written_byte(req_ch.data_byte, req_ch.cursor_row, req_ch.cursor_col);
         if (csr_wr_en)
            sb.write_emulate(csr_wr_data);
      end
   end

   function automatic logic [15:0] pick_coord();
      logic [15:0] c;
      case ($urandom_range(0, 6))
         0:       c = '0;
         1:       c = '1;
         2:       c = 16'($urandom_range(0, 9));
         3:       c = 16'($urandom_range(0, 999));
         4: begin
            // Values whose increment carries into a new decimal digit.
            case ($urandom_range(0, 3))
               0:       c = 16'd9;
               1:       c = 16'd99;
               2:       c = 16'd999;
               default: c = 16'd9999;
            endcase
         end
         default: c = 16'($urandom_range(0, 65535));
      endcase
      return c;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic [15:0] row,
                            input logic [15:0] col);
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.cursor_row <= row;
      req_ch.cursor_col <= col;
      do @(posedge clock); while (!req_ch.ready);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random_byte(input logic [7:0] b);
      send_byte(b, pick_coord(), pick_coord());
   endtask

   task automatic send_prefix(input int len);
      for (int j = 0; j < len; j++)
         send_random_byte(sb.query_chars[j]);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      // Waiting for a clock edge lets the scoreboard note the last accepted transaction.
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_emulation(input bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_prefix(4);
               sent += 4;
            end
            5, 6: begin
               // A query broken after a partial match.
               len = $urandom_range(1, 3);
               send_prefix(len);
               if ($urandom_range(0, 1))
                  send_random_byte(sb.query_chars[$urandom_range(0, 3)]);
               else
                  send_random_byte(8'($urandom_range(0, 255)));
               sent += len + 1;
            end
            7, 8: begin
               send_random_byte(8'($urandom_range(0, 255)));
               sent++;
            end
            default: begin
               send_random_byte(sb.query_chars[$urandom_range(0, 3)]);
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      hold_asked        = 0;
      send_idle_pct     = 20;
      recv_idle_pct     = 82;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.cursor_row <= '0;
      req_ch.cursor_col <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Replies at the coordinate extremes and across a digit carry.
      send_byte(cqi_pkg::CH_ESC, '0, '0);
      send_byte(cqi_pkg::CH_LBRACKET, '0, '0);
      send_byte(cqi_pkg::CH_SIX, '0, '0);
      send_byte(cqi_pkg::CH_LOWER_N, '0, '0);
      send_byte(cqi_pkg::CH_ESC, '1, '1);
      send_byte(cqi_pkg::CH_LBRACKET, '1, '1);
      send_byte(cqi_pkg::CH_SIX, '1, '1);
      send_byte(cqi_pkg::CH_LOWER_N, '1, '1);
      send_byte(cqi_pkg::CH_ESC, 16'd9, 16'd99);
      send_byte(cqi_pkg::CH_LBRACKET, 16'd9, 16'd99);
      send_byte(cqi_pkg::CH_SIX, 16'd9, 16'd99);
      send_byte(cqi_pkg::CH_LOWER_N, 16'd9, 16'd99);

      // Broken prefixes; the breaking escape does not start a new query.
      send_byte(cqi_pkg::CH_ESC, '0, '0);
      send_byte(cqi_pkg::CH_ESC, '0, '0);
      send_byte(cqi_pkg::CH_ESC, '0, '0);
      send_byte(cqi_pkg::CH_LBRACKET, '0, '0);
      send_byte(8'h00, '0, '0);
      send_byte(cqi_pkg::CH_ESC, '1, '0);
      send_byte(cqi_pkg::CH_LBRACKET, '1, '0);
      send_byte(cqi_pkg::CH_SIX, '1, '0);
      send_byte(8'hFF, '0, '1);

      // Emulation turned off while a prefix is held.
      send_byte(cqi_pkg::CH_ESC, '0, '0);
      send_byte(cqi_pkg::CH_LBRACKET, '0, '0);
      settle();
      write_emulation(1'b0);
      send_byte(cqi_pkg::CH_SIX, '0, '0);
      settle();
      write_emulation(1'b1);

      run_random(110);
      settle();
      write_emulation(1'b0);
      run_random(60);
      settle();
      write_emulation(1'b1);

      send_idle_pct = 82;
      recv_idle_pct = 20;
      run_random(60);
      wait_for_drain();
      run_random(60);
      settle();
      write_emulation(1'b0);
      run_random(40);
      settle();
      write_emulation(1'b1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked <= hold_asked + 1;
      run_random(60);
      wait_for_drain();
      run_random(60);

      settle();
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[cursor_query_interceptor.f]
rtl/cqi_pkg.sv
rtl/cqi_req_if.sv
rtl/cqi_rsp_if.sv
rtl/cqi_bcd.sv
rtl/cursor_query_interceptor.sv
verif/tb.sv
